// ===== hdl/i8dq_pkg.sv =====
//------------------------------------------------------------------------------
// i8dq_pkg
// Types and lane function for the int8 block dequantizer.
//------------------------------------------------------------------------------
`default_nettype none

package i8dq_pkg;

  typedef struct packed {
    logic [15:0]       scale_half;
    logic signed [7:0] quant_0;
    logic signed [7:0] quant_1;
    logic signed [7:0] quant_2;
    logic signed [7:0] quant_3;
    logic              last_in;
  } i8dq_in_t;

  typedef struct packed {
    logic [31:0] value_0;
    logic [31:0] value_1;
    logic [31:0] value_2;
    logic [31:0] value_3;
    logic        last_out;
  } i8dq_out_t;

  localparam logic [31:0] QnanDefault = 32'hFFC00000;
  localparam logic [7:0]  ExpInfNan   = 8'hFF;

  // One lane: half scale times signed int8 quant, exact binary32 result.
  function automatic logic [31:0] dq_lane(input logic [15:0] h, input logic [7:0] q);
    logic        hs;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic        qneg;
    logic [7:0]  qmag;
    logic        sgn;
    logic [10:0] sig;
    logic [17:0] prod;
    logic [4:0]  p;
    logic [7:0]  ex;
    logic [17:0] norm;
    logic [31:0] res;
    hs   = h[15];
    he   = h[14:10];
    hm   = h[9:0];
    qneg = q[7];
    qmag = qneg ? 8'(~q + 8'd1) : q;
    sgn  = hs ^ qneg;
    sig  = (he != 5'd0) ? {1'b1, hm} : {1'b0, hm};
    prod = 18'(sig) * 18'(qmag);
    p    = 5'd0;
    for (int i = 0; i < 18; i++) begin
      if (prod[i]) p = 5'(i);
    end
    // exponent: p + e - 10 + 127, e = he-15 (normal) or -14 (subnormal)
    ex   = 8'(p) + ((he != 5'd0) ? 8'(he) : 8'd1) + 8'd102;
    norm = prod << (5'd17 - p);
    if (he == 5'd31) begin
      if (hm != 10'd0) res = {hs, ExpInfNan, 1'b1, hm[8:0], 13'd0};
      else if (qmag == 8'd0) res = QnanDefault;
      else res = {sgn, ExpInfNan, 23'd0};
    end else if (prod == 18'd0) begin
      res = {sgn, 31'd0};
    end else begin
      res = {sgn, ex, norm[16:0], 6'd0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/int8_block_dequantizer_unit.sv =====
//------------------------------------------------------------------------------
// int8_block_dequantizer_unit
// Dequantizes four int8 quants against a half-precision scale to binary32.
//------------------------------------------------------------------------------
// channel | ports                        | payload
// input   | in_valid / in_ready          | i8dq_in_t  in_data
// result  | out_valid / out_ready        | i8dq_out_t out_data
//
// One request per cycle while out_ready holds; input register, then result register.
// Lane math is one 11x8 multiply plus leading-one search per lane.
// rst_n (synchronous) clears the valid flags only.
// The input register refills whenever the result register is free or drains.
//------------------------------------------------------------------------------
`default_nettype none

module int8_block_dequantizer_unit
  import i8dq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire i8dq_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output i8dq_out_t      out_data
);

  logic      in_vld_r, in_vld_nxt;
  i8dq_in_t  in_r;
  logic      out_vld_r, out_vld_nxt;
  i8dq_out_t out_r, res_nxt;
  logic      adv;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || adv;

  always_comb begin
    res_nxt.value_0  = dq_lane(in_r.scale_half, in_r.quant_0);
    res_nxt.value_1  = dq_lane(in_r.scale_half, in_r.quant_1);
    res_nxt.value_2  = dq_lane(in_r.scale_half, in_r.quant_2);
    res_nxt.value_3  = dq_lane(in_r.scale_half, in_r.quant_3);
    res_nxt.last_out = in_r.last_in;
    out_vld_nxt      = adv ? in_vld_r : out_vld_r;
    in_vld_nxt       = in_ready ? in_valid : in_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (in_ready && in_valid) in_r <= in_data;
    if (adv && in_vld_r) out_r <= res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r && out_vld_r)
    else $error("stall without full pipe");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && adv |=> out_valid)
    else $error("item lost between stages");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
//------------------------------------------------------------------------------
// tb: int8 block dequantizer unit
// Drives requests of half scale plus four int8 quants, predicts the exact
// binary32 products per lane and checks each result in order, with random
// sender gaps and receiver stalls.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import i8dq_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  i8dq_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  i8dq_out_t out_data;

  i8dq_out_t expected_q[$];
  int        errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        burst_left = 0;
  bit        stall_mode = 1'b0;

  always #5 clk = ~clk;

  int8_block_dequantizer_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // exact half * int8 as binary32
  function automatic logic [31:0] scaled_quant(logic [15:0] h, logic [7:0] q);
    logic        hs;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [7:0]  mag;
    logic        sgn;
    logic [10:0] sig;
    logic [31:0] prod;
    int          msb;
    int          ex;
    int          e;
    hs  = h[15];
    he  = h[14:10];
    hm  = h[9:0];
    mag = q[7] ? 8'(-q) : q;
    sgn = hs ^ q[7];
    if (he == 5'd31) begin
      if (hm != 0) return {hs, 8'hFF, 1'b1, hm[8:0], 13'd0};
      if (mag == 0) return QnanDefault;
      return {sgn, 8'hFF, 23'd0};
    end
    sig = (he != 0) ? {1'b1, hm} : {1'b0, hm};
    e   = (he != 0) ? int'(he) - 15 : -14;
    if (sig == 0 || mag == 0) return {sgn, 31'd0};
    prod = 32'(sig) * 32'(mag);
    msb  = 0;
    for (int i = 0; i < 32; i++) if (prod[i]) msb = i;
    ex = msb + e - 10 + 127;
    return {sgn, 8'(ex), 23'((prod << (23 - msb)) & 32'h7FFFFF)};
  endfunction

  task automatic send_request(logic [15:0] h, logic [7:0] q0, logic [7:0] q1,
                              logic [7:0] q2, logic [7:0] q3, logic last);
    i8dq_in_t  r;
    i8dq_out_t x;
    int        gap;
    r = '{h, q0, q1, q2, q3, last};
    x = '{scaled_quant(h, q0), scaled_quant(h, q1), scaled_quant(h, q2),
          scaled_quant(h, q3), last};
    // bursts with random gaps; valid drops only when a gap follows
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      burst_left = $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(x);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 9))
      0: return {1'($urandom), 5'd31, 10'($urandom)};
      1: return {1'($urandom), 5'd0, 10'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_special_scales();
    logic [15:0] scales[13] = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h0400,
      16'h3C00, 16'hBC00, 16'h7BFF, 16'hFBFF, 16'h7C00, 16'hFC00, 16'h7C01, 16'hFE55};
    foreach (scales[i]) send_request(scales[i], 8'h80, 8'h7F, 8'h00, 8'hFF, i[0]);
    send_request(16'h7FFF, 8'h00, 8'h01, 8'h80, 8'h55, 1'b1);
  endtask

  task automatic test_random_rows();
    logic [15:0] h;
    for (int n = 0; n < 1400; n += 8) begin
      h = rand_half();
      // one 32-quant block: eight requests sharing the scale, save about one in sixteen with a random scale
      for (int k = 0; k < 8; k++)
        send_request(($urandom_range(0, 15) == 0) ? rand_half() : h,
                     8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     (k == 7) ? 1'($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 30) == 0));
      if (n == 640) wait_drained();
    end
  endtask

  // receiver: alternates free-running and random stall stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_ready <= stall_mode ? 1'($urandom_range(0, 2) == 0) : 1'b1;
  end

  always @(posedge clk) begin
    i8dq_out_t x;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        x = expected_q.pop_front();
        n_checked++;
        if (out_data.value_0 !== x.value_0) begin
          $error("value_0 exp %h got %h", x.value_0, out_data.value_0); errors++;
        end
        if (out_data.value_1 !== x.value_1) begin
          $error("value_1 exp %h got %h", x.value_1, out_data.value_1); errors++;
        end
        if (out_data.value_2 !== x.value_2) begin
          $error("value_2 exp %h got %h", x.value_2, out_data.value_2); errors++;
        end
        if (out_data.value_3 !== x.value_3) begin
          $error("value_3 exp %h got %h", x.value_3, out_data.value_3); errors++;
        end
        if (out_data.last_out !== x.last_out) begin
          $error("last_out exp %b got %b", x.last_out, out_data.last_out); errors++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_scales();
    test_random_rows();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests (special scales, subnormals, inf/NaN, random rows);",
             n_sent);
    $display("%0d results checked against predicted binary32 lanes.", n_checked);
    if (errors == 0 && expected_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/i8dq_pkg.sv
hdl/int8_block_dequantizer_unit.sv
verif/tb.sv
